/* hdl/klh_pkg.sv */
// Package for the k-th largest selection block: sizes, shared types and the
// rank clamp. Depends on nothing; every module of the block imports it.
package klh_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DATA_W     = 32;
    localparam int K_W        = 7;

    typedef logic signed [DATA_W-1:0] data_t;

    // One input item as it leaves the front queue, with its clamped rank.
    typedef struct packed {
        data_t            value;
        logic             last;
        logic [CNT_W-1:0] keff;
    } item_t;

    typedef struct packed {
        data_t kth_value;
        logic  too_few;
    } result_t;

    // A rank of zero counts as one; a rank beyond the heap saturates to its depth.
    function automatic logic [CNT_W-1:0] eff_k(input logic [K_W-1:0] k);
        logic [31:0] kx;
        kx = 32'(k);
        if (kx == 32'd0)
            return CNT_W'(1);
        if (kx > 32'(HEAP_DEPTH))
            return CNT_W'(HEAP_DEPTH);
        return CNT_W'(kx);
    endfunction

endpackage

/* hdl/kth_largest_min_heap.sv */
// Top level of the k-th largest selection block: front queue, heap engine
// and result slot. Depends on klh_pkg, klh_front, klh_heap and klh_out.
//
//   channel   signals                         transfer when
//   input     push, full, value, last         push && !full
//   result    empty, pop, kth_value, too_few  pop && !empty
//   config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
// The heap engine handles one item at a time. An item that fills the heap
// rises, and a root replacement sinks, one level per read state and compare
// state; the single-write, dual-read heap memory sets that pace.
// Reset empties the heap at once through its fill count: no clearing pass.
// The two-entry front queue keeps taking items while the engine works until
// it is full, and a full result slot stalls the engine when a set ends.
module kth_largest_min_heap (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  klh_pkg::data_t           value,
    input  logic                     last,
    output logic                     empty,
    input  logic                     pop,
    output klh_pkg::data_t           kth_value,
    output logic                     too_few,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [klh_pkg::K_W-1:0]  cfg_data
);
    import klh_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    item_take;
    logic    res_valid;
    result_t res;
    logic    res_ready;

    // The rank register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    klh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value      (value),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    klh_heap u_heap (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    klh_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready),
        .empty      (empty),
        .pop        (pop),
        .kth_value  (kth_value),
        .too_few    (too_few)
    );

endmodule

/* hdl/klh_front.sv */
// Front end: holds the rank register and a two-entry input queue, and tags
// each item with its clamped rank. Depends on klh_pkg.
module klh_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  klh_pkg::data_t           value,
    input  logic                     last,
    input  logic                     cfg_valid,
    input  logic [klh_pkg::K_W-1:0]  cfg_data,
    output logic                     item_valid,
    output klh_pkg::item_t           item,
    input  logic                     item_take
);
    import klh_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic [K_W-1:0] k_reg;
    logic        do_push;
    logic        do_pop;

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            k_reg      <= K_W'(1);
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (cfg_valid)
                k_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg].value <= value;
            slot_reg[wr_ptr_reg].last  <= last;
            slot_reg[wr_ptr_reg].keff  <= eff_k(k_reg);
        end
    end

endmodule

/* hdl/klh_heap.sv */
// Back end: the heap memory and the sequencer that inserts, replaces the root
// and sinks, a heap level per read and compare state. Depends on klh_pkg.
module klh_heap (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  klh_pkg::item_t    item,
    output logic              item_take,
    output logic              res_valid,
    output klh_pkg::result_t  res,
    input  logic              res_ready
);
    import klh_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RISE_RD  = 3'd1;
    localparam logic [2:0] ST_RISE_CMP = 3'd2;
    localparam logic [2:0] ST_SINK_RD  = 3'd3;
    localparam logic [2:0] ST_SINK_CMP = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    data_t heap_mem [HEAP_DEPTH];

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] keff_reg, keff_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] child_reg, child_next;
    logic             right_ok_reg, right_ok_next;
    logic             last_reg, last_next;
    data_t            mv_reg, mv_next;
    data_t            root_reg;
    data_t            rd0_reg, rd1_reg;

    logic             we;
    logic [IDX_W-1:0] wa;
    data_t            wd;
    logic [IDX_W-1:0] ra0, ra1;

    logic [IDX_W-1:0] up_idx;
    logic [IDX_W+1:0] c_wide, c1_wide, size_wide;
    logic             pick_right;
    data_t            child_val;
    logic [IDX_W-1:0] child_idx;
    logic             too_few;

    assign up_idx     = (pos_reg - IDX_W'(1)) >> 1;
    assign c_wide     = {1'b0, pos_reg, 1'b1};
    assign c1_wide    = c_wide + (IDX_W+2)'(1);
    assign size_wide  = {1'b0, fill_reg};
    assign pick_right = right_ok_reg && (rd0_reg > rd1_reg);
    assign child_val  = pick_right ? rd1_reg : rd0_reg;
    assign child_idx  = pick_right ? child_reg + IDX_W'(1) : child_reg;
    assign too_few    = (fill_reg < keff_reg);

    assign res.too_few   = too_few;
    assign res.kth_value = too_few ? '0 : root_reg;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        keff_next     = keff_reg;
        pos_next      = pos_reg;
        child_next    = child_reg;
        right_ok_next = right_ok_reg;
        last_next     = last_reg;
        mv_next       = mv_reg;
        we            = 1'b0;
        wa            = pos_reg;
        wd            = mv_reg;
        ra0           = up_idx;
        ra1           = up_idx;
        item_take     = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_take = 1'b1;
                    last_next = item.last;
                    keff_next = item.keff;
                    mv_next   = item.value;
                    if (fill_reg < item.keff)
                    begin
                        pos_next   = fill_reg[IDX_W-1:0];
                        fill_next  = fill_reg + CNT_W'(1);
                        state_next = ST_RISE_RD;
                    end
                    else if ((fill_reg != '0) && (item.value > root_reg))
                    begin
                        pos_next   = '0;
                        state_next = ST_SINK_RD;
                    end
                    else
                        state_next = ST_DONE;
                end
            end

            ST_RISE_RD:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_RISE_CMP;
            end

            ST_RISE_CMP:
            begin
                we = 1'b1;
                if (rd0_reg > mv_reg)
                begin
                    wd         = rd0_reg;
                    pos_next   = up_idx;
                    state_next = ST_RISE_RD;
                end
                else
                    state_next = ST_DONE;
            end

            ST_SINK_RD:
            begin
                ra0 = c_wide[IDX_W-1:0];
                ra1 = c1_wide[IDX_W-1:0];
                child_next    = c_wide[IDX_W-1:0];
                right_ok_next = (c1_wide < size_wide);
                if (c_wide >= size_wide)
                begin
                    we         = 1'b1;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_SINK_CMP;
            end

            ST_SINK_CMP:
            begin
                we = 1'b1;
                if (mv_reg > child_val)
                begin
                    wd         = child_val;
                    pos_next   = child_idx;
                    state_next = ST_SINK_RD;
                end
                else
                    state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (res_ready)
                begin
                    res_valid  = 1'b1;
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keff_reg     <= keff_next;
        pos_reg      <= pos_next;
        child_reg    <= child_next;
        right_ok_reg <= right_ok_next;
        last_reg     <= last_next;
        mv_reg       <= mv_next;
        if (we && (wa == '0))
            root_reg <= wd;
    end

    // Heap memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
            heap_mem[wa] <= wd;
        rd0_reg <= heap_mem[ra0];
        rd1_reg <= heap_mem[ra1];
    end

endmodule

/* hdl/klh_out.sv */
// Result slot: a one-entry output register that shows the oldest result
// until it is popped. Depends on klh_pkg.
module klh_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  klh_pkg::result_t  res,
    output logic              res_ready,
    output logic              empty,
    input  logic              pop,
    output klh_pkg::data_t    kth_value,
    output logic              too_few
);
    import klh_pkg::*;

    logic    full_reg, full_next;
    result_t data_reg;

    assign empty     = !full_reg;
    assign res_ready = !full_reg || pop;
    assign kth_value = data_reg.kth_value;
    assign too_few   = data_reg.too_few;

    always_comb
    begin
        full_next = full_reg;
        if (pop && full_reg)
            full_next = 1'b0;
        if (res_valid)
            full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            data_reg <= res;
    end

endmodule

/* test/tb_top.sv */
// Testbench for kth_largest_min_heap: drives data sets through the input queue,
// predicts the k-th largest value of each set and checks every result transfer.
// Depends on klh_pkg and on the RTL of the block; reads no files.
`timescale 1ns / 100ps

// Keeps a software copy of the heap and the rank register, turns each accepted
// input transfer into the result it must cause, and checks results in order.
class rank_scoreboard;

    klh_pkg::data_t            heap[klh_pkg::HEAP_DEPTH];
    int                        fill;
    logic [klh_pkg::K_W-1:0]   rank_reg;
    klh_pkg::result_t          expected_q[$];
    int                        errors;
    int                        sets_closed;
    int                        results_seen;

    function new();
        fill         = 0;
        rank_reg     = 1;
        errors       = 0;
        sets_closed  = 0;
        results_seen = 0;
    endfunction

    task report(input string what);
        errors++;
        $display("tb_top: mismatch at %0t: %s", $realtime, what);
    endtask

    function void set_rank(input logic [klh_pkg::K_W-1:0] k);
        rank_reg = k;
    endfunction

    // Rank in force: zero acts as one, anything past the heap depth saturates.
    function int effective_rank();
        int k;
        k = int'(rank_reg);
        if (k == 0)
            k = 1;
        if (k > klh_pkg::HEAP_DEPTH)
            k = klh_pkg::HEAP_DEPTH;
        return k;
    endfunction

    function void swap_slots(input int a, input int b);
        klh_pkg::data_t t;
        t       = heap[a];
        heap[a] = heap[b];
        heap[b] = t;
    endfunction

    function void note_item(input klh_pkg::data_t v, input logic closes);
        int               k;
        int               pos;
        int               child;
        klh_pkg::result_t r;
        k = effective_rank();
        if (fill < k && fill < klh_pkg::HEAP_DEPTH) begin
            // Still filling: append and let the new entry rise.
            heap[fill] = v;
            pos = fill;
            while (pos > 0 && heap[(pos - 1) / 2] > heap[pos]) begin
                swap_slots((pos - 1) / 2, pos);
                pos = (pos - 1) / 2;
            end
            fill++;
        end else if (fill > 0 && v > heap[0]) begin
            // Replace the root and sink it; ties go to the left child.
            heap[0] = v;
            pos = 0;
            while (2 * pos + 1 < fill) begin
                child = 2 * pos + 1;
                if (child + 1 < fill && heap[child] > heap[child + 1])
                    child = child + 1;
                if (heap[pos] > heap[child]) begin
                    swap_slots(pos, child);
                    pos = child;
                end else begin
                    break;
                end
            end
        end
        if (closes) begin
            r.too_few   = (fill < k);
            r.kth_value = r.too_few ? '0 : heap[0];
            expected_q.insert(expected_q.size(), r);
            sets_closed++;
            fill = 0;
        end
    endfunction

    task check_result(input klh_pkg::data_t kth, input logic few);
        klh_pkg::result_t r;
        results_seen++;
        if (expected_q.size() == 0) begin
            report($sformatf("result kth_value=%0d too_few=%0b with none expected",
                             kth, few));
        end else begin
            r = expected_q.pop_front();
            if (few !== r.too_few)
                report($sformatf("too_few %0b, expected %0b", few, r.too_few));
            if (kth !== r.kth_value)
                report($sformatf("kth_value %0d, expected %0d", kth, r.kth_value));
        end
    endtask

    function int pending();
        return expected_q.size();
    endfunction

endclass

module tb_top;

    import klh_pkg::*;

    localparam data_t MAX_V       = 32'sh7fff_ffff;
    localparam data_t MIN_V       = 32'sh8000_0000;
    localparam int    ITEM_TARGET = 1450;
    localparam int    MIN_SETS    = 48;
    // A set that ends may have up to two items queued ahead of the engine; the
    // SETTLE wait covers any work still in flight.
    localparam int    SETTLE      = 64;
    localparam int    HOLD_LONG   = 300;
    // Cycles with no transfer on any channel before the run is declared hung;
    // the long receiver hold-off is the longest legitimate quiet stretch.
    localparam int    STALL_LIMIT = 4000;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            push      = 1'b0;
    logic            full;
    data_t           value     = '0;
    logic            last      = 1'b0;
    logic            empty;
    logic            pop       = 1'b0;
    data_t           kth_value;
    logic            too_few;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [K_W-1:0]  cfg_data  = '0;

    rank_scoreboard sb = new();

    int items_sent   = 0;
    int rank_writes  = 0;
    int idle_odds    = 4;   // 0 turns idling off; otherwise one chance in idle_odds
    int hold_req     = 0;
    int hold_left    = 0;
    int pop_gap      = 0;
    int quiet_cycles = 0;

    kth_largest_min_heap dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .last      (last),
        .empty     (empty),
        .pop       (pop),
        .kth_value (kth_value),
        .too_few   (too_few),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side. Outputs are sampled right at the rising edge, before the
    // block's own updates land, so the check sees what the edge transferred.
    // The receiver idles in short bursts, and once holds off for a long stretch
    // when the stimulus asks for it, so that the result slot and the input
    // queue fill and the block has to stall its input.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pop && !empty)
                sb.check_result(kth_value, too_few);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                pop_gap = $urandom_range(1, 3) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: any transfer on any channel resets the count of quiet cycles.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, sb.pending());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Offers one item and returns at the edge that transfers it. Push stays
    // high into the next call so back-to-back items stream without a gap.
    task automatic send_item(input data_t v, input logic closes);
        int gap;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            gap = $urandom_range(1, 3);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        value <= v;
        last  <= closes;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_item(v, closes);
        items_sent++;
    endtask

    // Waits for every expected result, then for any work still in flight, so
    // that the block is idle before the rank register is touched again.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_rank(input logic [K_W-1:0] k);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_rank(k);
        rank_writes++;
    endtask

    // Values: mostly full-range random, with a share of extremes and a share
    // drawn from a narrow band so that ties between heap entries are common.
    function automatic data_t pick_value();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            case ($urandom_range(0, 3))
                0:       return MAX_V;
                1:       return MIN_V;
                2:       return '0;
                default: return -32'sd1;
            endcase
        end
        if (mode <= 3)
            return data_t'($urandom_range(0, 15)) - 32'sd8;
        return data_t'($urandom);
    endfunction

    // Ranks: mostly small so that sets close often, sometimes anything the
    // register can hold, including the values that get clamped.
    function automatic logic [K_W-1:0] pick_rank();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode <= 5)
            return K_W'($urandom_range(1, 8));
        if (mode == 6)
            return K_W'($urandom_range(0, 127));
        if (mode == 7) begin
            case ($urandom_range(0, 3))
                0:       return K_W'(0);
                1:       return K_W'(64);
                2:       return K_W'(65);
                default: return K_W'(127);
            endcase
        end
        return K_W'($urandom_range(1, 3));
    endfunction

    // Set length around the rank in force: close to it, short of it (the
    // too-few case), or well past it so that many roots get replaced.
    function automatic int pick_length(input int k);
        int n;
        case ($urandom_range(0, 3))
            0:       n = $urandom_range(1, k);
            1:       n = k + $urandom_range(0, 20);
            default: n = k + $urandom_range(0, 6) - 2;
        endcase
        return (n < 1) ? 1 : n;
    endfunction

    initial
    begin
        int             n;
        int             sets;
        int             phase;
        logic [K_W-1:0] rk;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets. Rank one with a single extreme value each.
        write_rank(K_W'(1));
        send_item(MAX_V, 1'b1);
        send_item(MIN_V, 1'b1);
        settle();
        // Rank zero must behave as rank one.
        write_rank(K_W'(0));
        send_item(32'sd5, 1'b0);
        send_item(-32'sd3, 1'b1);
        settle();
        // Ties at the root and among children while filling and replacing.
        write_rank(K_W'(3));
        send_item(32'sd7, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(32'sd2, 1'b1);
        settle();
        // A set shorter than the rank reports too_few with a zero value.
        write_rank(K_W'(4));
        send_item(32'sd1, 1'b0);
        send_item(32'sd2, 1'b1);
        settle();
        // Rank raised in the middle of a set: the heap keeps growing.
        write_rank(K_W'(2));
        send_item(32'sd10, 1'b0);
        send_item(32'sd20, 1'b0);
        settle();
        write_rank(K_W'(5));
        send_item(32'sd30, 1'b0);
        send_item(32'sd5, 1'b1);
        settle();
        // Alternating extremes over a full two-entry heap.
        write_rank(K_W'(2));
        send_item(MIN_V, 1'b0);
        send_item(MAX_V, 1'b0);
        send_item(MIN_V, 1'b0);
        send_item(MAX_V, 1'b1);
        settle();

        // Back pressure: the receiver stops for a long stretch while one-item
        // sets keep coming, so every result slot and queue entry fills up.
        write_rank(K_W'(1));
        hold_req = HOLD_LONG;
        for (int i = 0; i < 24; i++)
            send_item(pick_value(), 1'b1);
        settle();

        // Random phases. The first four force the rank extremes; afterwards the
        // rank is random. Idling varies per phase and stops near the end.
        phase = 0;
        while (items_sent < ITEM_TARGET || sb.sets_closed < MIN_SETS) begin
            case (phase)
                0:       rk = K_W'(127);
                1:       rk = K_W'(64);
                2:       rk = K_W'(65);
                3:       rk = K_W'(0);
                default: rk = pick_rank();
            endcase
            phase++;
            if (items_sent >= ITEM_TARGET - 200)
                idle_odds = 0;
            else
                idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
            write_rank(rk);
            sets = (sb.effective_rank() > 16) ? 1 : $urandom_range(2, 8);
            for (int s = 0; s < sets; s++) begin
                n = pick_length(sb.effective_rank());
                for (int i = 0; i < n; i++)
                    send_item(pick_value(), i == n - 1);
            end
            // Now and then leave a set open across the next rank change.
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    send_item(pick_value(), 1'b0);
            end
            settle();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("tb_top: %0d items in %0d sets, %0d results checked, %0d rank writes",
                 items_sent, sb.sets_closed, sb.results_seen, rank_writes);
        $display("tb_top: ranks 0, 1, 64, 65 and 127, ties, short sets, mid-set rank change");
        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* kth_largest_min_heap.f */
hdl/klh_pkg.sv
hdl/klh_front.sv
hdl/klh_heap.sv
hdl/klh_out.sv
hdl/kth_largest_min_heap.sv
test/tb_top.sv
